// File: design/zhang_suen_thinning_pass_unit_defines.svh
// assertion macros for the thinning pass unit
// expects clk and rst_n in the scope of each use
`ifndef ZHANG_SUEN_THINNING_PASS_UNIT_DEFINES_SVH
`define ZHANG_SUEN_THINNING_PASS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ZST_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zst check failed in the same cycle");
`define ZST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zst check failed one cycle later");
`else
`define ZST_ASSERT_SAME(lbl, ante, cons)
`define ZST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/zst_pkg.sv
// shared types and constants for the thinning pass unit
// no dependencies
package zst_pkg;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_PASS     = 2'd2;

  localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 11'd1024;

  // bounds on the neighbor count of a removable pixel
  localparam logic [3:0] NEIGH_MIN = 4'd2;
  localparam logic [3:0] NEIGH_MAX = 4'd6;

  // one window column: bit0 top row, bit1 center row, bit2 bottom row
  typedef logic [2:0] column_t;

  typedef struct packed {
    logic pixel;
    logic removed;
  } judge_t;

endpackage

// File: design/zst_if.sv
// valid/ready channel interfaces for pixel words and result words
// depends on nothing
interface zst_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic flush;
  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink (input valid, input pixel_in, input flush, output ready);
endinterface

interface zst_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic removed;
  logic frame_last;
  modport source (output valid, output pixel_out, output removed, output frame_last,
                  input ready);
  modport sink (input valid, input pixel_out, input removed, input frame_last,
                output ready);
endinterface

// File: design/zst_judge.sv
// deletion test of one 3x3 window for a thinning sub-pass
// depends on zst_pkg
module zst_judge
  import zst_pkg::*;
(
  input  logic    sub_pass,
  input  column_t lc,
  input  column_t mc,
  input  column_t rc,
  output judge_t  res
);

  logic       p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic       c1, c2;
  logic [7:0] ring;
  logic [7:0] rise;
  logic [3:0] nb_cnt;
  logic [3:0] rise_cnt;

  assign p1 = mc[1];
  assign p2 = mc[0];
  assign p3 = rc[0];
  assign p4 = rc[1];
  assign p5 = rc[2];
  assign p6 = mc[2];
  assign p7 = lc[2];
  assign p8 = lc[1];
  assign p9 = lc[0];

  assign ring = {p9, p8, p7, p6, p5, p4, p3, p2};

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rise[k] = !ring[k] && ring[(k + 1) % 8];
    end
  end

  assign nb_cnt   = 4'($countones(ring));
  assign rise_cnt = 4'($countones(rise));

  assign c1 = sub_pass ? (p2 & p4 & p8) : (p2 & p4 & p6);
  assign c2 = sub_pass ? (p2 & p6 & p8) : (p4 & p6 & p8);

  always_comb begin
    if (p1 && !c1 && !c2 && nb_cnt >= NEIGH_MIN && nb_cnt <= NEIGH_MAX
        && rise_cnt == 4'd1) begin
      res.pixel   = 1'b0;
      res.removed = 1'b1;
    end else begin
      res.pixel   = p1;
      res.removed = 1'b0;
    end
  end

endmodule

// File: design/zst_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module zst_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/zhang_suen_thinning_pass_unit.sv
// channel   dir  modport     word
// in_s      in   sink        pixel_in, flush
// out_s     out  source      pixel_out, removed, frame_last
// cfg_*     in   write only  image_width, image_height, sub_pass
//
// one pixel word per clock unless out_s stalls; results pass stage a and output reg
// the line store read is issued at accept, the window test runs on the next stage
// reset is synchronous and clears counters, window and valid flags; no clearing pass
// a stalled output register holds the pipeline and drops in_s.ready
// depends on zst_pkg, zst_if, zst_judge, zst_ram and the defines header
`include "zhang_suen_thinning_pass_unit_defines.svh"

module zhang_suen_thinning_pass_unit
  import zst_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  zst_in_if.sink                in_s,
  zst_out_if.source             out_s,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int KW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int KH = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;

  // configuration
  logic [CFG_DATA_W-1:0] width_r, height_r;
  logic                  sub_pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= CFG_DIM_RESET;
      height_r   <= CFG_DIM_RESET;
      sub_pass_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r    <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r   <= cfg_data;
        CFG_SUB_PASS:     sub_pass_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [KW-1:0] w_ext;
  logic [KH-1:0] h_ext;
  logic [WW-1:0] w;
  logic [HW-1:0] h;

  always_comb begin
    w_ext = KW'(width_r);
    h_ext = KH'(height_r);
    if (w_ext == '0) begin
      w = WW'(1);
    end else if (w_ext > KW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(w_ext);
    end
    if (h_ext == '0) begin
      h = HW'(1);
    end else if (h_ext > KH'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(h_ext);
    end
  end

  // handshake
  logic a_vld_r, out_vld_r;
  logic b_free, a_move, in_fire;

  assign b_free     = !out_vld_r || out_s.ready;
  assign a_move     = a_vld_r && b_free;
  assign in_s.ready = !a_vld_r || a_move;
  assign in_fire    = in_s.valid && in_s.ready;

  // position of the accepted word
  logic [CW-1:0] col_r, col_nxt, c;
  logic [RW-1:0] row_r, row_nxt, r, r1, hp1;
  logic [WW-1:0] cp1;
  logic          col_wrap, pix, res_vld, res_last;

  always_comb begin
    hp1      = RW'(h) + RW'(1);
    col_wrap = (WW'(col_r) >= w);
    r1       = col_wrap ? row_r + RW'(1) : row_r;
    if (r1 > hp1) begin
      r = '0;
      c = '0;
    end else begin
      r = r1;
      c = col_wrap ? '0 : col_r;
    end
    pix = (r < RW'(h)) && !in_s.flush && in_s.pixel_in;
    if (c == '0) begin
      res_vld  = (r >= RW'(2)) && (r <= hp1);
      res_last = (r == hp1);
    end else begin
      res_vld  = (r >= RW'(1)) && (r <= RW'(h));
      res_last = 1'b0;
    end
    cp1 = WW'(c) + WW'(1);
    if (r >= hp1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cp1 >= w) begin
      col_nxt = '0;
      row_nxt = r + RW'(1);
    end else begin
      col_nxt = CW'(cp1);
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage a: word waiting for its line store data
  logic          a_pix_r, a_c0_r, a_r1_r, a_r2_r, a_res_r, a_last_r;
  logic [CW-1:0] a_addr_r;
  logic          fwd_r;
  logic [1:0]    fwd_data_r;
  logic [1:0]    ram_wdata, ram_rdata, mem_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (in_fire) begin
      a_vld_r <= 1'b1;
    end else if (a_move) begin
      a_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix_r    <= pix;
      a_c0_r     <= (c == '0);
      a_r1_r     <= (r >= RW'(1));
      a_r2_r     <= (r >= RW'(2));
      a_res_r    <= res_vld;
      a_last_r   <= res_last;
      a_addr_r   <= c;
      // one-pixel rows read the entry being written in the same cycle
      fwd_r      <= a_move && (a_addr_r == c);
      fwd_data_r <= ram_wdata;
    end
  end

  // entry bit1 is the middle row, bit0 the upper row
  assign mem_q     = fwd_r ? fwd_data_r : ram_rdata;
  assign ram_wdata = {a_pix_r, mem_q[1]};

  zst_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (a_move),
    .waddr (a_addr_r),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (c),
    .rdata (ram_rdata)
  );

  // window and test
  logic [5:0] win_r;
  column_t    newcol, rc;
  judge_t     jres;

  assign newcol = {a_pix_r, a_r1_r & mem_q[1], a_r2_r & mem_q[0]};
  assign rc     = a_c0_r ? column_t'(0) : newcol;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (a_move) begin
      win_r <= a_c0_r ? {newcol, 3'b000} : {newcol, win_r[5:3]};
    end
  end

  zst_judge u_judge (
    .sub_pass (sub_pass_r),
    .lc       (win_r[2:0]),
    .mc       (win_r[5:3]),
    .rc       (rc),
    .res      (jres)
  );

  // output register
  logic pix_out_r, removed_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (b_free) begin
      out_vld_r <= a_move && a_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move && a_res_r) begin
      pix_out_r <= jres.pixel;
      removed_r <= jres.removed;
      last_r    <= a_last_r;
    end
  end

  assign out_s.valid      = out_vld_r;
  assign out_s.pixel_out  = pix_out_r;
  assign out_s.removed    = removed_r;
  assign out_s.frame_last = last_r;

  `ZST_ASSERT_SAME(a_removed_clears_pixel, out_s.valid && out_s.removed, !out_s.pixel_out)
  `ZST_ASSERT_SAME(a_stall_only_on_full, !in_s.ready, a_vld_r && out_vld_r && !out_s.ready)
  `ZST_ASSERT_NEXT(a_accept_fills_stage, in_fire, a_vld_r)
  `ZST_ASSERT_NEXT(a_result_reaches_out, a_move && a_res_r, out_vld_r)

endmodule
